@@ rtl/assert_macros.svh @@
// Assertion macros shared by the combination unrank RTL.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("combination unrank assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("combination unrank assertion failed");

`endif

@@ rtl/cu_pkg.sv @@
// Shared constants and controller/datapath link types for the combination unrank block.
// No dependencies.
package cu_pkg;

   // Field widths of the request and response words.
   localparam int LEN_W   = 6;
   localparam int RANK_W  = 30;
   localparam int MASK_W  = 32;
   // Binomial width; C(32,16) still fits below 2**30.
   localparam int BINOM_W = 30;
   // Default longest mask.
   localparam int MAX_LEN_DEF = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture a new request word
      logic rd_total;  // look up C(length, ones) instead of the per-position count
      logic check;     // apply the range check
      logic step;      // decide one mask position
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic total_bad; // rank not below C(length, ones), or length too large
      logic last;      // one position remains
      logic empty;     // no positions remain
   } status_type;

endpackage

@@ rtl/cu_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on cu_pkg for field widths.

// Request channel: length, ones count and rank.
interface cu_req_if;
   logic                         valid;
   logic                         ready;
   logic [cu_pkg::LEN_W-1:0]     length;
   logic [cu_pkg::LEN_W-1:0]     ones_count;
   logic [cu_pkg::RANK_W-1:0]    rank_in;

   modport source (output valid, length, ones_count, rank_in, input ready);
   modport sink   (input valid, length, ones_count, rank_in, output ready);
endinterface

// Response channel: mask and range error flag.
interface cu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cu_pkg::MASK_W-1:0]    mask_out;
   logic                         range_error;

   modport source (output valid, mask_out, range_error, input ready);
   modport sink   (input valid, mask_out, range_error, output ready);
endinterface

@@ rtl/cu_datapath.sv @@
// Datapath: binomial ROM, running rank, ones left, position counter and mask.
// Depends on cu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cu_datapath #(
   parameter int MAX_LEN = cu_pkg::MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cu_pkg::cmd_type             cmd,
   output cu_pkg::status_type          status,
   input  logic [cu_pkg::LEN_W-1:0]    in_length,
   input  logic [cu_pkg::LEN_W-1:0]    in_ones,
   input  logic [cu_pkg::RANK_W-1:0]   in_rank,
   output logic [cu_pkg::MASK_W-1:0]   mask,
   output logic                        range_err
);

   localparam int ROM_DEPTH = (MAX_LEN + 1) * (MAX_LEN + 1);
   localparam int ADDR_W    = $clog2(ROM_DEPTH);
   localparam int POS_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   typedef logic [cu_pkg::BINOM_W-1:0] rom_type [0:ROM_DEPTH-1];

   // Pascal's triangle, row n at offset n*(MAX_LEN+1), built at elaboration.
   function automatic rom_type build_rom();
      rom_type                     r;
      logic [cu_pkg::BINOM_W-1:0]  row [0:MAX_LEN];
      for (int k = 0; k <= MAX_LEN; k++) begin
         row[k] = '0;
      end
      row[0] = cu_pkg::BINOM_W'(1);
      for (int n = 0; n <= MAX_LEN; n++) begin
         for (int k = n; k >= 1; k--) begin
            row[k] = row[k] + row[k-1];
         end
         for (int k = 0; k <= MAX_LEN; k++) begin
            r[n * (MAX_LEN + 1) + k] = row[k];
         end
      end
      return r;
   endfunction

   localparam rom_type BINOM_ROM = build_rom();

   logic [cu_pkg::LEN_W-1:0]    n_ff, n_in;
   logic [cu_pkg::LEN_W-1:0]    left_ff, left_in;
   logic [cu_pkg::RANK_W-1:0]   rank_ff, rank_in;
   logic [cu_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic                        err_ff, err_in;
   logic [cu_pkg::BINOM_W-1:0]  rom_q_ff;
   logic                        zero_ff;
   logic [cu_pkg::LEN_W-1:0]    rd_n;
   logic                        rd_ok;
   logic [ADDR_W-1:0]           rd_addr;
   logic [cu_pkg::BINOM_W-1:0]  count;
   logic                        take;

   // Lookup operands: C(n, left) for the range check, C(n-1, left) per position.
   always_comb begin
      rd_n    = cmd.rd_total ? n_ff : n_ff - cu_pkg::LEN_W'(1);
      rd_ok   = (rd_n <= cu_pkg::LEN_W'(MAX_LEN)) && (left_ff <= rd_n);
      rd_addr = rd_ok ? ADDR_W'(int'(rd_n) * (MAX_LEN + 1) + int'(left_ff)) : '0;
   end

   // Registered ROM read; entries with k above n read as zero.
   always_ff @(posedge clock) begin
      rom_q_ff <= BINOM_ROM[rd_addr];
      zero_ff  <= !rd_ok;
   end

   assign count = zero_ff ? '0 : rom_q_ff;
   assign take  = (cu_pkg::BINOM_W'(rank_ff) >= count);

   // Status back to the controller.
   always_comb begin
      status.total_bad = (n_ff > cu_pkg::LEN_W'(MAX_LEN)) || take;
      status.last      = (n_ff == cu_pkg::LEN_W'(1));
      status.empty     = (n_ff == '0);
   end

   // Next values of the working registers.
   always_comb begin
      n_in    = n_ff;
      left_in = left_ff;
      rank_in = rank_ff;
      mask_in = mask_ff;
      pos_in  = pos_ff;
      err_in  = err_ff;
      if (cmd.load) begin
         n_in    = in_length;
         left_in = in_ones;
         rank_in = in_rank;
         mask_in = '0;
         pos_in  = '0;
         err_in  = 1'b0;
      end else if (cmd.check) begin
         err_in = status.total_bad;
      end else if (cmd.step) begin
         n_in   = n_ff - cu_pkg::LEN_W'(1);
         pos_in = pos_ff + POS_W'(1);
         if (take) begin
            rank_in = rank_ff - cu_pkg::RANK_W'(count);
            mask_in = mask_ff | (cu_pkg::MASK_W'(1) << pos_ff);
            if (left_ff != '0) begin
               left_in = left_ff - cu_pkg::LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         err_ff  <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         err_ff  <= err_in;
      end
      n_ff    <= n_in;
      left_ff <= left_in;
      rank_ff <= rank_in;
      pos_ff  <= pos_in;
   end

   assign mask      = mask_ff;
   assign range_err = err_ff;

   // An error word always carries an empty mask.
   `CU_ASSERT_IMP(a_err_mask_zero, err_ff, mask_ff == '0)
   // A new request starts from a clean mask and no error.
   `CU_ASSERT_NEXT(a_load_clears, cmd.load, (mask_ff == '0) && !err_ff)

endmodule

@@ rtl/cu_ctrl.sv @@
// Controller state machine: handshakes and sequencing of the unrank datapath.
// Depends on cu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output cu_pkg::cmd_type     cmd,
   input  cu_pkg::status_type  status
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TOTREAD = 3'd1;
   localparam logic [2:0] S_TOTCHK  = 3'd2;
   localparam logic [2:0] S_RD      = 3'd3;
   localparam logic [2:0] S_UPD     = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign accept    = in_valid && in_ready;

   // Commands decode the state directly; load comes from the accepted handshake.
   always_comb begin
      cmd.load     = accept;
      cmd.rd_total = (state_ff == S_TOTREAD);
      cmd.check    = (state_ff == S_TOTCHK);
      cmd.step     = (state_ff == S_UPD);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_TOTREAD;
         end
         S_TOTREAD: state_in = S_TOTCHK;
         S_TOTCHK: begin
            if (status.total_bad || status.empty) state_in = S_DONE;
            else state_in = S_RD;
         end
         S_RD: state_in = S_UPD;
         S_UPD: begin
            if (status.last) state_in = S_DONE;
            else state_in = S_RD;
         end
         S_DONE: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted word always starts with the range lookup.
   `CU_ASSERT_NEXT(a_accept_starts, accept, state_ff == S_TOTREAD)
   // Deciding the last position finishes the word.
   `CU_ASSERT_NEXT(a_last_done, (state_ff == S_UPD) && status.last, state_ff == S_DONE)
   // A failed range check goes straight to the response.
   `CU_ASSERT_NEXT(a_bad_done, (state_ff == S_TOTCHK) && status.total_bad, state_ff == S_DONE)

endmodule

@@ rtl/combination_unrank.sv @@
// Combination unrank top level: request word (length, ones_count, rank_in) in,
// response word (mask_out, range_error) out, over valid/ready channels.
// Scans mask positions from bit 0 upward against a binomial ROM held in the datapath.
// After a word is accepted, the controller reads C(length, ones_count) and checks
// the range, then decides each mask position in turn; an out-of-range word answers
// straight after the check with range_error set and a zero mask. Each position
// takes a registered ROM read and then a compare-and-subtract on the running rank,
// which needs the previous position's ones count for its address.
// One word is in flight at a time; req_chan.ready is high only while idle, so a
// new word is taken only once the response to the last one has been taken.
// If the receiver stalls, the response word holds steady on rsp_chan until taken.
// Reset (synchronous, active high) returns the controller to idle and drops any
// word in progress; the binomial ROM is constant and needs no fill.
// A length above MAX_LEN, more ones than positions, or a rank at or above
// C(length, ones_count) all report range_error.
// Depends on cu_pkg, cu_if, cu_ctrl and cu_datapath.

module combination_unrank #(
   parameter int MAX_LEN = cu_pkg::MAX_LEN_DEF
) (
   input  logic     clock,
   input  logic     reset,
   cu_req_if.sink   req_chan,
   cu_rsp_if.source rsp_chan
);

   cu_pkg::cmd_type    cmd;
   cu_pkg::status_type status;

   // Sequencing and handshakes.
   cu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Binomial lookup and mask construction.
   cu_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_length (req_chan.length),
      .in_ones   (req_chan.ones_count),
      .in_rank   (req_chan.rank_in),
      .mask      (rsp_chan.mask_out),
      .range_err (rsp_chan.range_error)
   );

endmodule

@@ tb/tb_combination_unrank.sv @@
// Self-checking testbench for combination_unrank: drives request words, predicts each mask.
// Depends on cu_pkg, the cu_req_if/cu_rsp_if interfaces and the combination_unrank RTL.
`timescale 1ns / 1ps

module tb_combination_unrank;

   localparam int MAX_LEN       = 32;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int ITEMS_PER_RUN = 433;
   localparam int SHOWN_ERRORS  = 10;

   typedef struct packed {
      logic [cu_pkg::LEN_W-1:0]  length;
      logic [cu_pkg::LEN_W-1:0]  ones_count;
      logic [cu_pkg::RANK_W-1:0] rank_in;
   } request_type;

   typedef struct packed {
      logic [cu_pkg::MASK_W-1:0] mask_out;
      logic                      range_error;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cu_req_if req_chan ();
   cu_rsp_if rsp_chan ();

   combination_unrank #(.MAX_LEN(MAX_LEN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   request_type  pending_requests[$];
   response_type expected_masks[$];
   request_type  next_request;
   response_type expected;
   response_type observed;
   int           requests_queued   = 0;
   int           requests_accepted = 0;
   int           error_count       = 0;
   int           idle_cycles       = 0;
   int           send_idle_pct     = 0;
   int           recv_idle_pct     = 0;
   logic         req_taken         = 1'b0;

   always #1 clock = ~clock;

   // Exact binomial coefficient; zero when more are chosen than exist.
   function automatic longint unsigned choose_count(int n, int k);
      longint unsigned c;
      c = 1;
      if (k > n) return 0;
      if (k > n - k) k = n - k;
      for (int i = 0; i < k; i++) c = c * longint'(n - i) / longint'(i + 1);
      return c;
   endfunction

   // Expected response: scan positions upward, setting a bit whenever the rank
   // reaches the number of completions that leave it clear.
   function automatic response_type unrank_mask(request_type req);
      response_type    res;
      longint unsigned rank;
      longint unsigned zero_ways;
      int              len;
      int              left;
      len  = int'(req.length);
      left = int'(req.ones_count);
      rank = 64'(req.rank_in);
      res  = '0;
      if (len > MAX_LEN || rank >= choose_count(len, left)) begin
         res.range_error = 1'b1;
         return res;
      end
      for (int pos = 0; pos < len; pos++) begin
         zero_ways = choose_count(len - pos - 1, left);
         if (rank >= zero_ways) begin
            rank -= zero_ways;
            res.mask_out[pos] = 1'b1;
            if (left > 0) left--;
         end
      end
      return res;
   endfunction

   task automatic queue_request(int len, int ones, longint unsigned rank);
      request_type req;
      req.length     = cu_pkg::LEN_W'(len);
      req.ones_count = cu_pkg::LEN_W'(ones);
      req.rank_in    = cu_pkg::RANK_W'(rank);
      pending_requests.insert(pending_requests.size(), req);
      requests_queued++;
   endtask

   // Mostly well-formed requests with a random rank below the count, the rest
   // out-of-range ranks, surplus ones, overlong masks and raw noise.
   task automatic queue_random_request();
      int          pick;
      int          len;
      int          ones;
      int unsigned total;
      int unsigned rank;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         len   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 16) : $urandom_range(17, 32);
         ones  = $urandom_range(0, len);
         total = 32'(choose_count(len, ones));
         case ($urandom_range(0, 19))
            0:       rank = 0;
            1, 2:    rank = total - 1;
            default: rank = $urandom_range(0, total - 1);
         endcase
         queue_request(len, ones, rank);
      end else if (pick < 88) begin
         len   = $urandom_range(0, 32);
         ones  = $urandom_range(0, len);
         total = 32'(choose_count(len, ones));
         queue_request(len, ones, total + $urandom_range(0, 1000));
      end else if (pick < 93) begin
         len = $urandom_range(0, 31);
         queue_request(len, $urandom_range(len + 1, 63), $urandom_range(0, 3));
      end else if (pick < 97) begin
         queue_request($urandom_range(33, 63), $urandom_range(0, 63), $urandom());
      end else begin
         queue_request($urandom_range(0, 63), $urandom_range(0, 63), $urandom());
      end
   endtask

   // Request driver: a word is held until taken, then the next one may follow
   // or the sender may idle.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_request          = pending_requests.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.length      <= next_request.length;
            req_chan.ones_count  <= next_request.ones_count;
            req_chan.rank_in     <= next_request.rank_in;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: predict on each accepted request word, check each response word,
   // and watch for a stalled block.
   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_masks.insert(expected_masks.size(),
                               unrank_mask({req_chan.length, req_chan.ones_count,
                                            req_chan.rank_in}));
         requests_accepted++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         observed.mask_out    = rsp_chan.mask_out;
         observed.range_error = rsp_chan.range_error;
         if (expected_masks.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
               $display("unexpected response word: mask %h range_error %b",
                        observed.mask_out, observed.range_error);
         end else begin
            expected = expected_masks.pop_front();
            if (observed.mask_out !== expected.mask_out ||
                observed.range_error !== expected.range_error) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("mismatch: expected mask %h err %b, got mask %h err %b",
                           expected.mask_out, expected.range_error,
                           observed.mask_out, observed.range_error);
            end
         end
      end
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("combination_unrank regression: fail");
         $finish;
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      req_chan.valid      = 1'b0;
      req_chan.length     = '0;
      req_chan.ones_count = '0;
      req_chan.rank_in    = '0;
      rsp_chan.ready      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First run: sender idles a little, receiver often.
      send_idle_pct = 13;
      recv_idle_pct = 45;

      // Zero length, where only the empty mask at rank zero exists, and length one.
      queue_request(0, 0, 0);
      queue_request(0, 0, 1);
      queue_request(0, 1, 0);
      queue_request(1, 0, 0);
      queue_request(1, 1, 0);
      // Full length and one short of it, including all clear, all set and the widest count.
      queue_request(32, 0, 0);
      queue_request(32, 32, 0);
      queue_request(32, 1, 31);
      queue_request(32, 2, choose_count(32, 2) - 1);
      queue_request(32, 16, 0);
      queue_request(32, 16, choose_count(32, 16) - 1);
      queue_request(32, 16, choose_count(32, 16));
      queue_request(32, 16, (1 << cu_pkg::RANK_W) - 1);
      queue_request(32, 15, 'h1555_5555);
      queue_request(32, 31, 31);
      queue_request(31, 15, choose_count(31, 15) - 1);
      // Rank just inside and just at the boundary.
      queue_request(8, 4, 35);
      queue_request(8, 4, choose_count(8, 4) - 1);
      queue_request(8, 4, choose_count(8, 4));
      // More ones than positions.
      queue_request(5, 6, 0);
      queue_request(20, 63, 0);
      // Length above the longest mask.
      queue_request(33, 0, 0);
      queue_request(63, 63, (1 << cu_pkg::RANK_W) - 1);

      repeat (ITEMS_PER_RUN) queue_random_request();
      wait (requests_accepted == requests_queued);

      // Second run: idling swapped.
      send_idle_pct = 45;
      recv_idle_pct = 13;
      repeat (ITEMS_PER_RUN) queue_random_request();
      wait (requests_accepted == requests_queued);

      // Third run: full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (ITEMS_PER_RUN) queue_random_request();
      wait (requests_accepted == requests_queued);

      // Let the outstanding responses come back.
      while (expected_masks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_masks.size() != 0) error_count++;

      if (error_count == 0)
         $display("combination_unrank regression: pass");
      else
         $display("combination_unrank regression: fail");
      $finish;
   end

endmodule

@@ combination_unrank.f @@
+incdir+rtl
rtl/cu_pkg.sv
rtl/cu_if.sv
rtl/cu_datapath.sv
rtl/cu_ctrl.sv
rtl/combination_unrank.sv
tb/tb_combination_unrank.sv
